// File: sv/dgm_pkg.sv
// Shared constants, codes, stage types and helpers for the dial gauge measurement filter.
package dgm_pkg;

  // Fixed-point format and ring size
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned POS_W      = $clog2(RING_DEPTH);
  localparam int unsigned RAW_W      = 20;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = VAL_W + POS_W;

  // Opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ZERO   = 2'd1;
  localparam logic [1:0] OP_MODE   = 2'd2;

  // Measurement modes
  localparam logic [2:0] GM_ABSOLUTE = 3'd0;
  localparam logic [2:0] GM_RELATIVE = 3'd1;
  localparam logic [2:0] GM_PEAK_HI  = 3'd2;
  localparam logic [2:0] GM_PEAK_LO  = 3'd3;
  localparam logic [2:0] GM_RUNOUT   = 3'd4;

  // Tolerance classes
  localparam logic [1:0] TOL_WITHIN = 2'd0;
  localparam logic [1:0] TOL_BELOW  = 2'd1;
  localparam logic [1:0] TOL_ABOVE  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_AVG_SELECT   = 3'd0;
  localparam logic [2:0] REG_SENSOR_SETUP = 3'd1;
  localparam logic [2:0] REG_UNIT_INCH    = 3'd2;
  localparam logic [2:0] REG_RESOLUTION   = 3'd3;
  localparam logic [2:0] REG_TOL_ENABLE   = 3'd4;
  localparam logic [2:0] REG_TOL_STANDARD = 3'd5;
  localparam logic [2:0] REG_TOL_UPPER    = 3'd6;
  localparam logic [2:0] REG_TOL_LOWER    = 3'd7;

  // Scaling: mag = floor((raw * 2^s + (d-1)/2) / d) after cancelling common factors.
  // s is FRAC_BITS-4 for 0.5 um counts and FRAC_BITS-3 for 1 um counts;
  // d is 125 for millimetres and 3175 for inches.
  localparam int unsigned SHIFT_HALF = FRAC_BITS - 4;
  localparam int unsigned SHIFT_FULL = FRAC_BITS - 3;
  localparam longint unsigned DEN_MM = 125;
  localparam longint unsigned DEN_IN = 3175;
  localparam int unsigned L_MM = 7;
  localparam int unsigned L_IN = 12;
  localparam int unsigned RECIP_MM_SH = 32 + L_MM;
  localparam int unsigned RECIP_IN_SH = 32 + L_IN;

  localparam logic [15:0] Q_MM_HALF = 16'((64'd1 << SHIFT_HALF) / DEN_MM);
  localparam logic [15:0] Q_MM_FULL = 16'((64'd1 << SHIFT_FULL) / DEN_MM);
  localparam logic [15:0] Q_IN_HALF = 16'((64'd1 << SHIFT_HALF) / DEN_IN);
  localparam logic [15:0] Q_IN_FULL = 16'((64'd1 << SHIFT_FULL) / DEN_IN);
  localparam logic [11:0] R_MM_HALF = 12'((64'd1 << SHIFT_HALF) % DEN_MM);
  localparam logic [11:0] R_MM_FULL = 12'((64'd1 << SHIFT_FULL) % DEN_MM);
  localparam logic [11:0] R_IN_HALF = 12'((64'd1 << SHIFT_HALF) % DEN_IN);
  localparam logic [11:0] R_IN_FULL = 12'((64'd1 << SHIFT_FULL) % DEN_IN);
  localparam logic [11:0] H_MM = 12'((DEN_MM - 1) / 2);
  localparam logic [11:0] H_IN = 12'((DEN_IN - 1) / 2);
  localparam logic [32:0] M_MM = 33'(((64'd1 << RECIP_MM_SH) + DEN_MM - 1) / DEN_MM);
  localparam logic [32:0] M_IN = 33'(((64'd1 << RECIP_IN_SH) + DEN_IN - 1) / DEN_IN);

  localparam logic [31:0] MAG_MAX  = 32'h7FFF_FFFF;
  localparam logic [32:0] DEADBAND = 33'(((64'd1 << FRAC_BITS) + 2500) / 5000);

  // Divide-by-ten reciprocal for values below 10000
  localparam logic [15:0] TENTH_M  = 16'd52429;
  localparam int unsigned TENTH_SH = 19;

  // Stage payloads
  typedef struct packed {
    logic [1:0]  op;
    logic        sv;
    logic        neg;
    logic [2:0]  new_mode;
    logic [31:0] t;
    logic [35:0] p;
  } s1_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               sv;
    logic [2:0]         new_mode;
    logic signed [31:0] v;
  } s2_t;

  typedef struct packed {
    logic               upd;
    logic signed [31:0] shown;
    logic [2:0]         mode;
  } s3_t;

  typedef struct packed {
    logic               upd;
    logic signed [31:0] shown;
    logic [2:0]         mode;
    logic [1:0]         tol;
    logic [13:0]        x;
  } s4_t;

  // Clamp a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [32:0] a);
    logic signed [31:0] res;
    if (a[32] == a[31]) begin
      res = a[31:0];
    end else if (a[32]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

// File: sv/dgm_if.sv
// Channel interfaces for samples, results and configuration writes.
interface dgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       sample_valid;
  logic [19:0] raw_magnitude;
  logic       raw_negative;
  logic [2:0] new_mode;
  modport source(output valid, opcode, sample_valid, raw_magnitude, raw_negative, new_mode,
                 input ready);
  modport sink(input valid, opcode, sample_valid, raw_magnitude, raw_negative, new_mode,
               output ready);
endinterface

interface dgm_out_if;
  logic               valid;
  logic               ready;
  logic               updated;
  logic signed [31:0] display_value;
  logic [3:0]         pointer_digit;
  logic [1:0]         tol_class;
  logic [2:0]         active_mode;
  modport source(output valid, updated, display_value, pointer_digit, tol_class, active_mode,
                 input ready);
  modport sink(input valid, updated, display_value, pointer_digit, tol_class, active_mode,
               output ready);
endinterface

interface dgm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/dial_gauge_measure_filter_core.sv
// Dial gauge measurement front end: scaling, moving average, deadband, modes, hand, tolerance.
// Five-stage pipeline that accepts one beat per clock while the result side does not stall
// and returns one result beat per input beat. Stages one and two scale the count (a reduced
// quotient plus a 33-bit reciprocal multiply), stage three holds the filter ring, running
// sum, offsets, peaks and mode, stage four classifies tolerance and scales the hand
// fraction, stage five takes the hand digit and holds the result beat. Each stage advances
// on its own, so bubbles close up while the result side stalls. Configuration writes are
// taken every cycle.
module dial_gauge_measure_filter_core (
  input  logic         clk,
  input  logic         rst_n,
  dgm_in_if.sink       in_ch,
  dgm_out_if.source    out_ch,
  dgm_cfg_if.sink      cfg_ch
);

  // Configuration registers
  logic [1:0]         avg_sel_r;
  logic [1:0]         setup_r;
  logic               inch_r;
  logic [1:0]         res_r;
  logic               tol_en_r;
  logic signed [31:0] tol_std_r;
  logic signed [31:0] tol_up_r;
  logic signed [31:0] tol_lo_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_sel_r <= 2'd0;
      setup_r   <= 2'd0;
      inch_r    <= 1'b0;
      res_r     <= 2'd2;
      tol_en_r  <= 1'b0;
      tol_std_r <= '0;
      tol_up_r  <= '0;
      tol_lo_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dgm_pkg::REG_AVG_SELECT:   avg_sel_r <= cfg_ch.data[1:0];
        dgm_pkg::REG_SENSOR_SETUP: setup_r   <= cfg_ch.data[1:0];
        dgm_pkg::REG_UNIT_INCH:    inch_r    <= cfg_ch.data[0];
        dgm_pkg::REG_RESOLUTION:   res_r     <= cfg_ch.data[1:0];
        dgm_pkg::REG_TOL_ENABLE:   tol_en_r  <= cfg_ch.data[0];
        dgm_pkg::REG_TOL_STANDARD: tol_std_r <= cfg_ch.data;
        dgm_pkg::REG_TOL_UPPER:    tol_up_r  <= cfg_ch.data;
        dgm_pkg::REG_TOL_LOWER:    tol_lo_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic acc1, acc2, acc3, acc4, acc5;

  assign acc5 = !v5_r || out_ch.ready;
  assign acc4 = !v4_r || acc5;
  assign acc3 = !v3_r || acc4;
  assign acc2 = !v2_r || acc3;
  assign acc1 = !v1_r || acc2;
  assign in_ch.ready = acc1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (acc1) v1_r <= in_ch.valid;
      if (acc2) v2_r <= v1_r;
      if (acc3) v3_r <= v2_r;
      if (acc4) v4_r <= v3_r;
      if (acc5) v5_r <= v4_r;
    end
  end

  // Stage 1: split the scaling into quotient and remainder parts
  dgm_pkg::s1_t s1_r, s1_nxt;
  logic [15:0]  q_sel;
  logic [11:0]  r_sel;
  logic [11:0]  h_sel;

  always_comb begin
    case ({inch_r, setup_r[0]})
      2'b00: begin q_sel = dgm_pkg::Q_MM_HALF; r_sel = dgm_pkg::R_MM_HALF; end
      2'b01: begin q_sel = dgm_pkg::Q_MM_FULL; r_sel = dgm_pkg::R_MM_FULL; end
      2'b10: begin q_sel = dgm_pkg::Q_IN_HALF; r_sel = dgm_pkg::R_IN_HALF; end
      default: begin q_sel = dgm_pkg::Q_IN_FULL; r_sel = dgm_pkg::R_IN_FULL; end
    endcase
    h_sel = inch_r ? dgm_pkg::H_IN : dgm_pkg::H_MM;
    s1_nxt.op       = in_ch.opcode;
    s1_nxt.sv       = in_ch.sample_valid;
    s1_nxt.neg      = in_ch.raw_negative ^ setup_r[1];
    s1_nxt.new_mode = in_ch.new_mode;
    s1_nxt.t        = 32'({12'd0, in_ch.raw_magnitude} * {20'd0, r_sel}) + {20'd0, h_sel};
    s1_nxt.p        = {16'd0, in_ch.raw_magnitude} * {20'd0, q_sel};
  end

  always_ff @(posedge clk) begin
    if (acc1) s1_r <= s1_nxt;
  end

  // Stage 2: reciprocal divide of the remainder part, clamp and sign
  dgm_pkg::s2_t s2_r, s2_nxt;
  logic [64:0]  recip_prod;
  logic [31:0]  q2;
  logic [36:0]  mag_full;
  logic [31:0]  mag;

  always_comb begin
    recip_prod = {33'd0, s1_r.t} * {32'd0, (inch_r ? dgm_pkg::M_IN : dgm_pkg::M_MM)};
    q2 = inch_r ? 32'(recip_prod >> dgm_pkg::RECIP_IN_SH)
                : 32'(recip_prod >> dgm_pkg::RECIP_MM_SH);
    mag_full = {1'b0, s1_r.p} + {5'd0, q2};
    mag = (mag_full > {5'd0, dgm_pkg::MAG_MAX}) ? dgm_pkg::MAG_MAX : mag_full[31:0];
    s2_nxt.op       = s1_r.op;
    s2_nxt.sv       = s1_r.sv;
    s2_nxt.new_mode = s1_r.new_mode;
    s2_nxt.v        = s1_r.neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (acc2) s2_r <= s2_nxt;
  end

  // Stage 3: filter ring, deadband and measurement modes
  logic signed [31:0] ring_r [dgm_pkg::RING_DEPTH];
  logic [dgm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic signed [dgm_pkg::SUM_W-1:0] total_r, total_nxt;
  logic               primed_r;
  logic [1:0]         prev_sel_r;
  logic signed [31:0] last_r, last_nxt;
  logic signed [31:0] abs_off_r, abs_off_nxt;
  logic signed [31:0] rel_off_r, rel_off_nxt;
  logic signed [31:0] peak_hi_r, peak_hi_nxt;
  logic signed [31:0] peak_lo_r, peak_lo_nxt;
  logic signed [31:0] shown_r, shown_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic               upd3;
  logic               take;
  logic               refill;
  logic [2:0]         avg_sh;
  logic [dgm_pkg::POS_W-1:0] pos_mask;
  logic signed [dgm_pkg::SUM_W-1:0] v_ext;
  logic signed [dgm_pkg::SUM_W-1:0] avg_wide;
  logic signed [31:0] avg;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic               en3;
  dgm_pkg::s3_t       s3_r;

  assign en3  = acc3 && v2_r;
  assign take = (s2_r.op == dgm_pkg::OP_SAMPLE) && s2_r.sv;

  always_comb begin
    case (avg_sel_r)
      2'd0:    avg_sh = 3'd0;
      2'd1:    avg_sh = 3'd2;
      2'd2:    avg_sh = 3'd3;
      default: avg_sh = 3'd4;
    endcase
    pos_mask = dgm_pkg::POS_W'((1 << avg_sh) - 1);
    refill   = (avg_sel_r != prev_sel_r) || !primed_r;
    v_ext    = dgm_pkg::SUM_W'(s2_r.v);

    // Advance the running sum and the ring position
    if (refill) begin
      total_nxt = v_ext <<< avg_sh;
      pos_nxt   = dgm_pkg::POS_W'(1) & pos_mask;
    end else begin
      total_nxt = total_r + v_ext - dgm_pkg::SUM_W'(ring_r[pos_r]);
      pos_nxt   = (pos_r + dgm_pkg::POS_W'(1)) & pos_mask;
    end
    avg_wide = total_nxt >>> avg_sh;
    avg      = avg_wide[31:0];
    diff     = 33'(avg) - 33'(last_r);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    last_nxt    = last_r;
    abs_off_nxt = abs_off_r;
    rel_off_nxt = rel_off_r;
    peak_hi_nxt = peak_hi_r;
    peak_lo_nxt = peak_lo_r;
    shown_nxt   = shown_r;
    mode_nxt    = mode_r;
    upd3        = 1'b0;

    case (s2_r.op)
      dgm_pkg::OP_SAMPLE: begin
        if (s2_r.sv && (diff_mag >= dgm_pkg::DEADBAND)) begin
          upd3     = 1'b1;
          last_nxt = avg;
          case (mode_r)
            dgm_pkg::GM_ABSOLUTE: shown_nxt = dgm_pkg::sat32(33'(avg) - 33'(abs_off_r));
            dgm_pkg::GM_RELATIVE: shown_nxt = dgm_pkg::sat32(33'(avg) - 33'(rel_off_r));
            dgm_pkg::GM_PEAK_HI: begin
              if (avg > peak_hi_r) peak_hi_nxt = avg;
              shown_nxt = peak_hi_nxt;
            end
            dgm_pkg::GM_PEAK_LO: begin
              if (avg < peak_lo_r) peak_lo_nxt = avg;
              shown_nxt = peak_lo_nxt;
            end
            default: begin
              if (avg > peak_hi_r) peak_hi_nxt = avg;
              if (avg < peak_lo_r) peak_lo_nxt = avg;
              shown_nxt = dgm_pkg::sat32(33'(peak_hi_nxt) - 33'(peak_lo_nxt));
            end
          endcase
        end
      end
      dgm_pkg::OP_ZERO: begin
        if (mode_r == dgm_pkg::GM_ABSOLUTE) begin
          abs_off_nxt = dgm_pkg::sat32(33'(abs_off_r) + 33'(shown_r));
        end else begin
          rel_off_nxt = dgm_pkg::sat32(33'(rel_off_r) + 33'(shown_r));
        end
      end
      dgm_pkg::OP_MODE: begin
        if (s2_r.new_mode <= dgm_pkg::GM_RUNOUT) begin
          if ((mode_r == dgm_pkg::GM_ABSOLUTE) && (s2_r.new_mode == dgm_pkg::GM_RELATIVE)) begin
            rel_off_nxt = dgm_pkg::sat32(33'(shown_r) + 33'(abs_off_r));
            shown_nxt   = '0;
          end
          mode_nxt = s2_r.new_mode;
          if (s2_r.new_mode >= dgm_pkg::GM_PEAK_HI) begin
            peak_hi_nxt = shown_nxt;
            peak_lo_nxt = shown_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  // Write the ring: refill all entries or replace the oldest
  always_ff @(posedge clk) begin
    if (en3 && take) begin
      for (int i = 0; i < dgm_pkg::RING_DEPTH; i++) begin
        if (refill || (pos_r == dgm_pkg::POS_W'(i))) ring_r[i] <= s2_r.v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      total_r    <= '0;
      primed_r   <= 1'b0;
      prev_sel_r <= 2'd0;
      last_r     <= '0;
      abs_off_r  <= '0;
      rel_off_r  <= '0;
      peak_hi_r  <= '0;
      peak_lo_r  <= '0;
      shown_r    <= '0;
      mode_r     <= dgm_pkg::GM_ABSOLUTE;
    end else if (en3) begin
      if (take) begin
        pos_r      <= pos_nxt;
        total_r    <= total_nxt;
        primed_r   <= 1'b1;
        prev_sel_r <= avg_sel_r;
      end
      last_r    <= last_nxt;
      abs_off_r <= abs_off_nxt;
      rel_off_r <= rel_off_nxt;
      peak_hi_r <= peak_hi_nxt;
      peak_lo_r <= peak_lo_nxt;
      shown_r   <= shown_nxt;
      mode_r    <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc3) begin
      s3_r.upd   <= upd3;
      s3_r.shown <= shown_nxt;
      s3_r.mode  <= mode_nxt;
    end
  end

  // Stage 4: tolerance class and hand fraction scaling
  logic [1:0]         tol_r, tol_nxt;
  logic [31:0]        shown_mag;
  logic [dgm_pkg::FRAC_BITS-1:0] frac;
  logic [13:0]        digit_k;
  logic [dgm_pkg::FRAC_BITS+13:0] frac_prod;
  logic signed [32:0] dev;
  dgm_pkg::s4_t       s4_r;

  always_comb begin
    shown_mag = s3_r.shown[31] ? 32'(-s3_r.shown) : 32'(s3_r.shown);
    frac      = shown_mag[dgm_pkg::FRAC_BITS-1:0];
    case (res_r)
      2'd0:    digit_k = 14'd10000;
      2'd1:    digit_k = 14'd1000;
      2'd2:    digit_k = 14'd100;
      default: digit_k = 14'd0;
    endcase
    frac_prod = {14'd0, frac} * {{dgm_pkg::FRAC_BITS{1'b0}}, digit_k};
    dev = 33'(s3_r.shown) - 33'(tol_std_r);
    tol_nxt = tol_r;
    if (s3_r.upd && tol_en_r) begin
      if (dev < 33'(tol_lo_r)) begin
        tol_nxt = dgm_pkg::TOL_BELOW;
      end else if (dev > 33'(tol_up_r)) begin
        tol_nxt = dgm_pkg::TOL_ABOVE;
      end else begin
        tol_nxt = dgm_pkg::TOL_WITHIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= dgm_pkg::TOL_WITHIN;
    end else if (acc4 && v3_r) begin
      tol_r <= tol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc4) begin
      s4_r.upd   <= s3_r.upd;
      s4_r.shown <= s3_r.shown;
      s4_r.mode  <= s3_r.mode;
      s4_r.tol   <= tol_nxt;
      s4_r.x     <= 14'(frac_prod >> dgm_pkg::FRAC_BITS);
    end
  end

  // Stage 5: hand digit and result beat
  logic [3:0]  digit_r, digit_nxt;
  logic [29:0] tenth_prod;
  logic [10:0] tenth;
  logic [13:0] digit_wide;
  dgm_pkg::s4_t out_r;

  always_comb begin
    tenth_prod = {16'd0, s4_r.x} * {14'd0, dgm_pkg::TENTH_M};
    tenth      = 11'(tenth_prod >> dgm_pkg::TENTH_SH);
    digit_wide = s4_r.x - 14'({tenth, 3'd0} + {2'd0, tenth, 1'b0});
    digit_nxt  = s4_r.upd ? digit_wide[3:0] : digit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 4'd0;
    end else if (acc5 && v4_r) begin
      digit_r <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc5) begin
      out_r.upd   <= s4_r.upd;
      out_r.shown <= s4_r.shown;
      out_r.mode  <= s4_r.mode;
      out_r.tol   <= s4_r.tol;
      out_r.x     <= {10'd0, digit_nxt};
    end
  end

  assign out_ch.valid         = v5_r;
  assign out_ch.updated       = out_r.upd;
  assign out_ch.display_value = out_r.shown;
  assign out_ch.pointer_digit = out_r.x[3:0];
  assign out_ch.tol_class     = out_r.tol;
  assign out_ch.active_mode   = out_r.mode;

  // Checks
  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> ((prev_sel_r == 2'd0 && pos_r == '0) || (prev_sel_r == 2'd1 && pos_r < 4)
               || (prev_sel_r == 2'd2 && pos_r < 8) || (prev_sel_r == 2'd3)))
    else $error("ring position beyond averaging depth");

  a_unprimed_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (pos_r == '0))
    else $error("ring position moved before priming");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r <= 4'd9)
    else $error("hand digit out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !v3_r && !v4_r && !v5_r) |-> in_ch.ready)
    else $error("empty pipeline refuses input");

endmodule
